// ----- rtl/mtg_pkg.sv -----
// Shared constants and types for the MT19937 generator core.
`timescale 1ns / 1ps
`default_nettype none
package mtg_pkg;

  localparam int unsigned WORDS     = 624;
  localparam int unsigned SHIFT_OFF = 397;
  localparam int unsigned AW        = 10;
  localparam int unsigned DW        = 32;

  localparam logic [AW-1:0] LAST_IDX  = AW'(WORDS - 1);
  localparam logic [AW-1:0] NUM_WORDS = AW'(WORDS);
  localparam logic [AW-1:0] UNSEEDED  = AW'(WORDS + 1);
  localparam logic [AW-1:0] OFF_FWD   = AW'(SHIFT_OFF);
  localparam logic [AW-1:0] OFF_BACK  = AW'(WORDS - SHIFT_OFF);

  localparam logic [DW-1:0] TWIST_XOR    = 32'h9908_b0df;
  localparam logic [DW-1:0] TEMPER_B     = 32'h9d2c_5680;
  localparam logic [DW-1:0] TEMPER_C     = 32'hefc6_0000;
  localparam logic [DW-1:0] LCG_MULT     = 32'd69069;
  localparam logic [DW-1:0] DEFAULT_SEED = 32'd4357;

  localparam logic [1:0] OP_DRAW = 2'd0;
  localparam logic [1:0] OP_SEED = 2'd1;
  localparam logic [1:0] OP_LOAD = 2'd2;

  typedef struct packed {
    logic          en;
    logic [AW-1:0] addr;
    logic [DW-1:0] data;
  } wr_req_t;

  typedef struct packed {
    logic          en;
    logic [AW-1:0] addr;
  } rd_req_t;

endpackage
`default_nettype wire

// ----- rtl/mersenne_twister_generator_core.sv -----
// Top level of the MT19937 generator: command decode, seeding and bulk twist sequencer.
`timescale 1ns / 1ps
`default_nettype none
// MT19937 word generator. Issue an item with start while busy is low; in_op
// selects draw, seed (LCG fill from in_seed_value) or load (one state word).
// A draw returns its tempered word on out_random_word with out_valid high for
// one cycle, after the state memory read and the temper output register; the
// receiver cannot stall, so the strobe must be captured when it appears. While
// state words remain, draws are accepted every cycle (one read of the state
// memory each). The draw that finds the state used up holds busy while the bulk
// twist runs at one word per cycle through the dual-read state memory, then
// returns its word. A seed item holds busy while the single LCG multiplier
// takes two steps per state word. A draw before any seed or load first seeds
// with 4357 and then twists. Loads and unused op codes finish in the cycle they
// are taken. No clearing pass runs after reset: the state memory is meaningless
// until seeded or loaded.
module mersenne_twister_generator_core
  import mtg_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  output logic               busy,
  input  wire logic [1:0]    in_op,
  input  wire logic [31:0]   in_seed_value,
  input  wire logic [9:0]    in_word_index,
  input  wire logic [31:0]   in_word_value,
  output logic               out_valid,
  output logic    [31:0]     out_random_word
);

  // sequencer states
  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SEED   = 3'd1;
  localparam logic [2:0] ST_TPRIME = 3'd2;
  localparam logic [2:0] ST_TRUN   = 3'd3;
  localparam logic [2:0] ST_TDRAIN = 3'd4;
  localparam logic [2:0] ST_DRAW   = 3'd5;

  logic [2:0]    state_r, state_nxt;
  logic [AW-1:0] pos_r, pos_nxt;       // next word to hand out, UNSEEDED after reset
  logic          dr_v_r, dr_v_nxt;     // draw read in flight
  // LCG seeding
  logic [DW-1:0] s_r, s_nxt;
  logic [15:0]   hi_r, hi_nxt;
  logic          ph_r, ph_nxt;
  logic [AW-1:0] sidx_r, sidx_nxt;
  logic          pend_r, pend_nxt;     // twist and draw owed after seeding
  // twist pipeline
  logic [AW-1:0] k_r, k_nxt;           // index whose operands are being read
  logic          prime_r, prime_nxt;   // old word 0 arrives from port A
  logic          tw_v_r, tw_v_nxt;     // operands for tw_wk_r are on the read ports
  logic [AW-1:0] tw_wk_r, tw_wk_nxt;
  logic [DW-1:0] cur_r, cur_nxt;       // old value of the word being rewritten

  wr_req_t       wr;
  rd_req_t       rda, rdb;
  logic [DW-1:0] rda_data, rdb_data;

  logic [DW-1:0] lcg_next;
  logic [AW-1:0] k_succ, k_far;
  logic [DW-1:0] tw_y, tw_word;

  assign lcg_next = s_r * LCG_MULT + 32'd1;
  assign k_succ   = (k_r == LAST_IDX) ? '0 : k_r + 10'd1;
  assign k_far    = (k_r < OFF_BACK) ? k_r + OFF_FWD : k_r - OFF_BACK;

  // new word from old[k], word k+1 (old, or new word 0 at the wrap) and word
  // k+397 (new once that index has wrapped below k)
  always_comb begin
    tw_y    = {cur_r[31], rda_data[30:0]};
    tw_word = rdb_data ^ (tw_y >> 1) ^ (tw_y[0] ? TWIST_XOR : '0);
  end

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    dr_v_nxt  = 1'b0;
    s_nxt     = s_r;
    hi_nxt    = hi_r;
    ph_nxt    = ph_r;
    sidx_nxt  = sidx_r;
    pend_nxt  = pend_r;
    k_nxt     = k_r;
    prime_nxt = 1'b0;
    tw_v_nxt  = 1'b0;
    tw_wk_nxt = tw_wk_r;
    cur_nxt   = cur_r;
    wr        = '0;
    rda.en    = 1'b0;
    rda.addr  = pos_r;
    rdb.en    = 1'b0;
    rdb.addr  = k_far;

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (in_op)
            OP_DRAW: begin
              if (pos_r < NUM_WORDS) begin
                rda.en   = 1'b1;
                pos_nxt  = pos_r + 10'd1;
                dr_v_nxt = 1'b1;
              end else if (pos_r == UNSEEDED) begin
                s_nxt     = DEFAULT_SEED;
                ph_nxt    = 1'b0;
                sidx_nxt  = '0;
                pend_nxt  = 1'b1;
                state_nxt = ST_SEED;
              end else begin
                state_nxt = ST_TPRIME;
              end
            end
            OP_SEED: begin
              s_nxt     = in_seed_value;
              ph_nxt    = 1'b0;
              sidx_nxt  = '0;
              pend_nxt  = 1'b0;
              state_nxt = ST_SEED;
            end
            OP_LOAD: begin
              if (in_word_index < NUM_WORDS) begin
                wr.en   = 1'b1;
                wr.addr = in_word_index;
                wr.data = in_word_value;
                pos_nxt = NUM_WORDS;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SEED: begin
        s_nxt = lcg_next;
        if (!ph_r) begin
          hi_nxt = s_r[31:16];
          ph_nxt = 1'b1;
        end else begin
          ph_nxt  = 1'b0;
          wr.en   = 1'b1;
          wr.addr = sidx_r;
          wr.data = {hi_r, s_r[31:16]};
          if (sidx_r == LAST_IDX) begin
            pos_nxt   = NUM_WORDS;
            state_nxt = pend_r ? ST_TPRIME : ST_IDLE;
          end else begin
            sidx_nxt = sidx_r + 10'd1;
          end
        end
      end
      ST_TPRIME: begin
        rda.en    = 1'b1;
        rda.addr  = '0;
        prime_nxt = 1'b1;
        k_nxt     = '0;
        state_nxt = ST_TRUN;
      end
      ST_TRUN: begin
        rda.en    = 1'b1;
        rda.addr  = k_succ;
        rdb.en    = 1'b1;
        tw_v_nxt  = 1'b1;
        tw_wk_nxt = k_r;
        if (k_r == LAST_IDX) begin
          state_nxt = ST_TDRAIN;
        end else begin
          k_nxt = k_r + 10'd1;
        end
      end
      ST_TDRAIN: begin
        pos_nxt   = '0;
        pend_nxt  = 1'b0;
        state_nxt = ST_DRAW;
      end
      ST_DRAW: begin
        rda.en    = 1'b1;
        pos_nxt   = pos_r + 10'd1;
        dr_v_nxt  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    if (prime_r) begin
      cur_nxt = rda_data;
    end
    // twist write-back; never overlaps a seed or load write
    if (tw_v_r) begin
      wr.en   = 1'b1;
      wr.addr = tw_wk_r;
      wr.data = tw_word;
      cur_nxt = rda_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pos_r   <= UNSEEDED;
      dr_v_r  <= 1'b0;
      pend_r  <= 1'b0;
      prime_r <= 1'b0;
      tw_v_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      dr_v_r  <= dr_v_nxt;
      pend_r  <= pend_nxt;
      prime_r <= prime_nxt;
      tw_v_r  <= tw_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s_r     <= s_nxt;
    hi_r    <= hi_nxt;
    ph_r    <= ph_nxt;
    sidx_r  <= sidx_nxt;
    k_r     <= k_nxt;
    tw_wk_r <= tw_wk_nxt;
    cur_r   <= cur_nxt;
  end

  assign busy = (state_r != ST_IDLE);

  mtg_ram u_ram (
    .clk      (clk),
    .wr       (wr),
    .rda      (rda),
    .rdb      (rdb),
    .rda_data (rda_data),
    .rdb_data (rdb_data)
  );

  mtg_temper u_temper (
    .clk             (clk),
    .rst_n           (rst_n),
    .raw_valid       (dr_v_r),
    .raw_word        (rda_data),
    .out_valid       (out_valid),
    .out_random_word (out_random_word)
  );

endmodule
`default_nettype wire

// ----- rtl/mtg_ram.sv -----
// State word memory: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none
module mtg_ram
  import mtg_pkg::*;
(
  input  wire logic          clk,
  input  wire wr_req_t       wr,
  input  wire rd_req_t       rda,
  input  wire rd_req_t       rdb,
  output logic    [DW-1:0]   rda_data,
  output logic    [DW-1:0]   rdb_data
);

  logic [DW-1:0] mem [WORDS];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rda.en) begin
      rda_data <= mem[rda.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rdb.en) begin
      rdb_data <= mem[rdb.addr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/mtg_temper.sv -----
// Output stage: tempers a raw state word and drives the result strobe.
`timescale 1ns / 1ps
`default_nettype none
module mtg_temper
  import mtg_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          raw_valid,
  input  wire logic [DW-1:0] raw_word,
  output logic               out_valid,
  output logic    [DW-1:0]   out_random_word
);

  logic [DW-1:0] y1, y2, y3, y4;

  always_comb begin
    y1 = raw_word ^ (raw_word >> 11);
    y2 = y1 ^ ((y1 << 7) & TEMPER_B);
    y3 = y2 ^ ((y2 << 15) & TEMPER_C);
    y4 = y3 ^ (y3 >> 18);
  end

  logic          valid_r;
  logic [DW-1:0] word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= raw_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (raw_valid) begin
      word_r <= y4;
    end
  end

  assign out_valid       = valid_r;
  assign out_random_word = word_r;

endmodule
`default_nettype wire

// ----- rtl/mtg_checker.sv -----
// Port-level checks for the generator core, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module mtg_checker
  import mtg_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        start,
  input wire logic        busy,
  input wire logic [1:0]  in_op,
  input wire logic        out_valid
);

  // reset leaves no result strobe behind
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  // busy only rises after an accepted item
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an accepted item");

  // a seed always occupies the block
  a_seed_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_op == OP_SEED) |=> busy)
    else $error("seed item did not raise busy");

  // only draws produce results
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_op != OP_DRAW) |=> ##1 !out_valid)
    else $error("result after a non-draw item");

endmodule

bind mersenne_twister_generator_core mtg_checker u_mtg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_op     (in_op),
  .out_valid (out_valid)
);
`default_nettype wire

// ----- tb/mersenne_twister_generator_core_test.sv -----
// Self-checking testbench for the MT19937 generator core: directed and random items.
`timescale 1ns / 1ps
module mersenne_twister_generator_core_test;
  import mtg_pkg::*;

  // Spare op code; the core ignores it.
  localparam logic [1:0]  OP_SPARE     = 2'd3;
  localparam logic [31:0] UPPER_HALF   = 32'hffff_0000;
  localparam logic [31:0] HIGH_BIT     = 32'h8000_0000;
  localparam logic [31:0] LOW_BITS     = 32'h7fff_ffff;
  localparam logic [31:0] ALL_ONES     = 32'hffff_ffff;
  // Worst item is a self-seed plus bulk twist; the run limit is several times
  // the slowest clean run.
  localparam int unsigned RUN_LIMIT    = 4_000_000;
  localparam int unsigned RANDOM_ITEMS = 800;
  localparam int unsigned LONG_RUN     = 640;
  localparam int unsigned DRAIN_CYCLES = 16;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_op;
  logic [31:0] in_seed_value;
  logic [9:0]  in_word_index;
  logic [31:0] in_word_value;
  logic        out_valid;
  logic [31:0] out_random_word;

  mersenne_twister_generator_core uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_seed_value   (in_seed_value),
    .in_word_index   (in_word_index),
    .in_word_value   (in_word_value),
    .out_valid       (out_valid),
    .out_random_word (out_random_word)
  );

  always #5 clk = ~clk;

  // Predictor copy of the generator state.
  logic [31:0] gen_words [0:WORDS-1];
  logic [9:0]  gen_pos;
  logic [31:0] words_due [$];
  logic [31:0] due_word;

  int errors        = 0;
  int words_checked = 0;
  int draws_sent    = 0;
  int seeds_sent    = 0;
  int loads_sent    = 0;
  int ignored_sent  = 0;
  int burst_left    = 0;
  int cycle_count   = 0;

  // 69069 LCG fill, two LCG steps per state word.
  function automatic void lcg_fill(input logic [31:0] s);
    logic [31:0] w;
    for (int i = 0; i < WORDS; i++) begin
      w = s & UPPER_HALF;
      s = LCG_MULT * s + 32'd1;
      w |= (s & UPPER_HALF) >> 16;
      s = LCG_MULT * s + 32'd1;
      gen_words[i] = w;
    end
    gen_pos = NUM_WORDS;
  endfunction

  function automatic void twist_state();
    logic [31:0] y;
    logic [31:0] v;
    for (int k = 0; k < WORDS; k++) begin
      y = (gen_words[k] & HIGH_BIT) | (gen_words[(k + 1) % WORDS] & LOW_BITS);
      v = gen_words[(k + SHIFT_OFF) % WORDS] ^ (y >> 1);
      if (y[0]) v ^= TWIST_XOR;
      gen_words[k] = v;
    end
    gen_pos = '0;
  endfunction

  function automatic logic [31:0] temper(input logic [31:0] y);
    y ^= y >> 11;
    y ^= (y << 7) & TEMPER_B;
    y ^= (y << 15) & TEMPER_C;
    y ^= y >> 18;
    return y;
  endfunction

  // Steps the predictor for one accepted item; a draw queues its word.
  function automatic void advance_generator(input logic [1:0] op, input logic [31:0] seed,
                                            input logic [9:0] idx, input logic [31:0] val);
    case (op)
      OP_DRAW: begin
        if (gen_pos >= NUM_WORDS) begin
          if (gen_pos == UNSEEDED) lcg_fill(DEFAULT_SEED);
          twist_state();
        end
        words_due.push_back(temper(gen_words[gen_pos]));
        gen_pos = gen_pos + 10'd1;
        draws_sent++;
      end
      OP_SEED: begin
        lcg_fill(seed);
        seeds_sent++;
      end
      OP_LOAD: begin
        if (idx < NUM_WORDS) begin
          gen_words[idx] = val;
          gen_pos = NUM_WORDS;
          loads_sent++;
        end else begin
          ignored_sent++;
        end
      end
      default: ignored_sent++;
    endcase
  endfunction

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return ALL_ONES;
      default: return $urandom();
    endcase
  endfunction

  // Sender pacing: bursts of random length, usually with an idle gap between.
  task automatic pace();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0) begin
        start         <= 1'b0;
        in_op         <= 2'($urandom());
        in_seed_value <= $urandom();
        in_word_index <= 10'($urandom());
        in_word_value <= $urandom();
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  // Start stays high on return so back-to-back items need no new edge on it.
  task automatic send_item(input logic [1:0] op, input logic [31:0] seed,
                           input logic [9:0] idx, input logic [31:0] val);
    pace();
    start         <= 1'b1;
    in_op         <= op;
    in_seed_value <= seed;
    in_word_index <= idx;
    in_word_value <= val;
    @(posedge clk);
    while (busy) @(posedge clk);
    advance_generator(op, seed, idx, val);
  endtask

  task automatic send_draw();
    send_item(OP_DRAW, $urandom(), 10'($urandom()), $urandom());
  endtask

  task automatic send_seed(input logic [31:0] s);
    send_item(OP_SEED, s, 10'($urandom()), $urandom());
  endtask

  task automatic send_load(input logic [9:0] idx, input logic [31:0] val);
    send_item(OP_LOAD, $urandom(), idx, val);
  endtask

  // Ignored items before any seed, then draws that must self-seed with the default.
  task automatic test_unseeded_draw();
    send_load(10'h3ff, $urandom());
    send_load(NUM_WORDS, $urandom());
    send_item(OP_SPARE, $urandom(), 10'($urandom()), $urandom());
    repeat (3) send_draw();
  endtask

  task automatic test_seed_extremes();
    send_seed('0);
    repeat (2) send_draw();
    send_seed(ALL_ONES);
    repeat (2) send_draw();
    send_seed(DEFAULT_SEED);
    send_draw();
    send_seed($urandom());
    send_draw();
  endtask

  // Loads at both ends of the store force a twist on the next draw.
  task automatic test_state_load();
    send_load('0, '0);
    send_load(LAST_IDX, ALL_ONES);
    repeat (2) send_draw();
    send_load(10'd512, ALL_ONES);
    send_draw();
    send_load(10'h3ff, ALL_ONES);
    send_draw();
    send_load(NUM_WORDS, '0);
    send_draw();
  endtask

  // One long run crosses the natural twist, then a mix of sequences and noise.
  task automatic test_random_mix();
    int counted_start;
    counted_start = draws_sent + seeds_sent + loads_sent;
    send_seed(pick_word());
    repeat (LONG_RUN) send_draw();
    while (draws_sent + seeds_sent + loads_sent - counted_start < RANDOM_ITEMS) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10: begin
          repeat ($urandom_range(1, 40)) send_draw();
        end
        11, 12, 13: begin
          send_seed(pick_word());
          repeat ($urandom_range(1, 30)) send_draw();
        end
        14, 15, 16: begin
          repeat ($urandom_range(1, 4)) send_load(10'($urandom_range(0, WORDS - 1)), pick_word());
          repeat ($urandom_range(1, 10)) send_draw();
        end
        17: send_load(10'($urandom_range(WORDS, 1023)), pick_word());
        default: send_item(OP_SPARE, $urandom(), 10'($urandom()), $urandom());
      endcase
    end
  endtask

  // Results cannot be held off: every strobe is checked against the oldest word due.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (words_due.size() == 0) begin
        $display("%0t: unexpected random_word: expected none, got %h", $time, out_random_word);
        errors++;
      end else begin
        due_word = words_due.pop_front();
        words_checked++;
        if (out_random_word !== due_word) begin
          $display("%0t: random_word mismatch: expected %h, got %h",
                   $time, due_word, out_random_word);
          errors++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout with %0d words still due", $time, words_due.size());
    $display("mersenne_twister_generator_core_test: done, errors");
    $finish;
  end

  initial begin
    for (int i = 0; i < WORDS; i++) gen_words[i] = '0;
    gen_pos       = UNSEEDED;
    rst_n         <= 1'b0;
    start         <= 1'b0;
    in_op         <= OP_DRAW;
    in_seed_value <= '0;
    in_word_index <= '0;
    in_word_value <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_unseeded_draw();
    test_seed_extremes();
    test_state_load();
    test_random_mix();

    start <= 1'b0;
    while (words_due.size() != 0 || busy) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d draws (%0d words compared), %0d seeds, %0d state loads,",
             draws_sent, words_checked, seeds_sent, loads_sent);
    $display("%0d ignored items, self-seeding and both twist paths.", ignored_sent);
    if (errors == 0) begin
      $display("mersenne_twister_generator_core_test: done, clean");
    end else begin
      $display("mersenne_twister_generator_core_test: done, errors");
    end
    $finish;
  end

endmodule
